// File: hw/rtl/jpfo_pkg.sv
`default_nettype none
package jpfo_pkg;
    localparam int MAX_POINTS_DEF = 32;
    localparam int CNT_W = 7;
    localparam int PT_W = 16;
    localparam int VAL_W = 18;
    localparam int DIF_W = 19;
    localparam int SQ_W = 38;
    localparam logic [SQ_W-1:0] ONE_SQ = SQ_W'(1) << 28;

    typedef struct packed {
        logic valid;
        logic center;
        logic [CNT_W-1:0] pos;
        logic [CNT_W-1:0] step;
        logic signed [VAL_W-1:0] x;
        logic signed [VAL_W-1:0] y;
    } issue_t;

    typedef struct packed {
        logic found;
        logic [CNT_W-1:0] pos;
        logic signed [VAL_W-1:0] x;
        logic signed [VAL_W-1:0] y;
    } best_t;
endpackage
`default_nettype wire

// File: hw/rtl/jitter_point_farthest_ordering.sv
// Points are loaded one item per cycle into a ring of cells; the item with last_point set
// closes the set. Ordering then rotates the ring once per pass while a pipelined distance
// unit scans the head cell: one pass finds the center, and each chain step applies the
// previous swap while it searches, plus one last pass to apply the final swap. After the
// last pass the results follow, one result per cycle while out_ready is high. The block
// accepts no new point until all results of a set are delivered.
`default_nettype none
module jitter_point_farthest_ordering
#(
    parameter int MAX_POINTS = jpfo_pkg::MAX_POINTS_DEF
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               point_valid,
    output logic                                    point_ready,
    input  wire logic signed [jpfo_pkg::PT_W-1:0]   point_x,
    input  wire logic signed [jpfo_pkg::PT_W-1:0]   point_y,
    input  wire logic                               last_point,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic signed [jpfo_pkg::VAL_W-1:0]       out_x,
    output logic signed [jpfo_pkg::VAL_W-1:0]       out_y,
    output logic                                    out_last
);
    localparam int CW = jpfo_pkg::CNT_W;
    localparam int VW = jpfo_pkg::VAL_W;

    typedef enum logic [3:0] {
        S_LOAD  = 4'b0001,
        S_PASS  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_EMIT  = 4'b1000
    } state_t;

    state_t                state_reg, state_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [CW-1:0]         n_reg, n_next;
    logic [CW-1:0]         pos_reg, pos_next;
    logic [CW-1:0]         step_reg, step_next;
    logic                  center_reg, center_next;
    logic                  scan_reg, scan_next;
    logic                  xform_reg, xform_next;
    logic                  swap_reg, swap_next;
    logic [CW-1:0]         sa_reg, sa_next;
    logic [CW-1:0]         sb_reg, sb_next;
    logic signed [VW-1:0]  vax_reg, vax_next, vay_reg, vay_next;
    logic signed [VW-1:0]  vbx_reg, vbx_next, vby_reg, vby_next;
    logic signed [VW-1:0]  cenx_reg, cenx_next, ceny_reg, ceny_next;
    logic signed [VW-1:0]  refx_reg, refx_next, refy_reg, refy_next;
    logic signed [VW-1:0]  oldx_reg, oldx_next, oldy_reg, oldy_next;

    logic signed [VW-1:0]  cx [MAX_POINTS];
    logic signed [VW-1:0]  cy [MAX_POINTS];
    logic signed [VW-1:0]  rawx, rawy, effx, effy;
    logic signed [VW:0]    dfx, dfy;
    logic                  accept_in, rotate, start, clr, clr_center, busy;
    logic [CW-1:0]         cap_pos;
    jpfo_pkg::issue_t      issue;
    jpfo_pkg::best_t       best;

    assign accept_in = point_valid && point_ready;
    assign point_ready = (state_reg == S_LOAD);
    assign out_valid = (state_reg == S_EMIT);
    assign out_x = cx[0];
    assign out_y = cy[0];
    assign out_last = (pos_reg == n_reg - CW'(1));
    assign rotate = (state_reg == S_PASS) || (out_valid && out_ready);

    always_comb
    begin
        rawx = cx[0];
        rawy = cy[0];
        if (swap_reg && pos_reg == sa_reg)
        begin
            rawx = vax_reg;
            rawy = vay_reg;
        end
        else if (swap_reg && pos_reg == sb_reg)
        begin
            rawx = vbx_reg;
            rawy = vby_reg;
        end
        dfx = (VW+1)'(rawx) - (VW+1)'(cenx_reg);
        dfy = (VW+1)'(rawy) - (VW+1)'(ceny_reg);
        effx = xform_reg ? {dfx[VW-2:0], 1'b0} : rawx;
        effy = xform_reg ? {dfy[VW-2:0], 1'b0} : rawy;
    end

    genvar k;
    generate
        for (k = 0; k < MAX_POINTS; k++)
        begin : g_cell
            jpfo_cell u_cell
            (
                .clk      (clk),
                .load_en  (accept_in && cnt_reg == CW'(k)),
                .shift_en (rotate),
                .is_tail  (n_reg == CW'(k + 1)),
                .pt_x     (VW'(point_x)),
                .pt_y     (VW'(point_y)),
                .nb_x     ((k == MAX_POINTS - 1) ? effx : cx[(k + 1) % MAX_POINTS]),
                .nb_y     ((k == MAX_POINTS - 1) ? effy : cy[(k + 1) % MAX_POINTS]),
                .ret_x    (effx),
                .ret_y    (effy),
                .x        (cx[k]),
                .y        (cy[k])
            );
        end
    endgenerate

    always_comb
    begin
        issue.valid = (state_reg == S_PASS) && (center_reg || scan_reg);
        issue.center = center_reg;
        issue.pos = pos_reg;
        issue.step = step_reg;
        issue.x = effx;
        issue.y = effy;
    end

    jpfo_dist u_dist
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .issue      (issue),
        .ref_x      (refx_reg),
        .ref_y      (refy_reg),
        .clr        (clr),
        .clr_center (clr_center),
        .busy       (busy),
        .best       (best)
    );

    assign cap_pos = center_reg ? '0 : step_reg + CW'(1);

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        n_next = n_reg;
        pos_next = pos_reg;
        step_next = step_reg;
        center_next = center_reg;
        scan_next = scan_reg;
        xform_next = xform_reg;
        swap_next = swap_reg;
        sa_next = sa_reg;
        sb_next = sb_reg;
        vax_next = vax_reg;
        vay_next = vay_reg;
        vbx_next = vbx_reg;
        vby_next = vby_reg;
        cenx_next = cenx_reg;
        ceny_next = ceny_reg;
        refx_next = refx_reg;
        refy_next = refy_reg;
        oldx_next = oldx_reg;
        oldy_next = oldy_reg;
        start = 1'b0;
        clr = 1'b0;
        clr_center = 1'b0;
        case (state_reg)
            S_LOAD:
            begin
                if (accept_in)
                begin
                    if (cnt_reg < CW'(MAX_POINTS))
                    begin
                        cnt_next = cnt_reg + CW'(1);
                    end
                    if (last_point)
                    begin
                        n_next = cnt_next;
                        state_next = S_PASS;
                        pos_next = '0;
                        center_next = 1'b1;
                        scan_next = 1'b0;
                        xform_next = 1'b0;
                        swap_next = 1'b0;
                        cenx_next = '0;
                        ceny_next = '0;
                        refx_next = '0;
                        refy_next = '0;
                        clr = 1'b1;
                        clr_center = 1'b1;
                    end
                end
            end
            S_PASS:
            begin
                if (pos_reg == cap_pos)
                begin
                    oldx_next = effx;
                    oldy_next = effy;
                end
                pos_next = pos_reg + CW'(1);
                if (pos_reg == n_reg - CW'(1))
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!busy)
                begin
                    start = 1'b1;
                    pos_next = '0;
                    clr = 1'b1;
                    state_next = S_PASS;
                    if (center_reg)
                    begin
                        cenx_next = best.found ? best.x : oldx_reg;
                        ceny_next = best.found ? best.y : oldy_reg;
                        sa_next = '0;
                        sb_next = best.found ? best.pos : '0;
                        vax_next = cenx_next;
                        vay_next = ceny_next;
                        vbx_next = oldx_reg;
                        vby_next = oldy_reg;
                        swap_next = 1'b1;
                        xform_next = 1'b1;
                        center_next = 1'b0;
                        scan_next = (n_reg >= CW'(3));
                        step_next = '0;
                        refx_next = '0;
                        refy_next = '0;
                    end
                    else if (scan_reg)
                    begin
                        swap_next = best.found;
                        sa_next = step_reg + CW'(1);
                        sb_next = best.pos;
                        vax_next = best.x;
                        vay_next = best.y;
                        vbx_next = oldx_reg;
                        vby_next = oldy_reg;
                        refx_next = best.found ? best.x : oldx_reg;
                        refy_next = best.found ? best.y : oldy_reg;
                        xform_next = 1'b0;
                        step_next = step_reg + CW'(1);
                        scan_next = ((step_reg + CW'(4)) <= n_reg);
                    end
                    else
                    begin
                        swap_next = 1'b0;
                        xform_next = 1'b0;
                        state_next = S_EMIT;
                    end
                end
            end
            S_EMIT:
            begin
                if (out_ready)
                begin
                    pos_next = pos_reg + CW'(1);
                    if (out_last)
                    begin
                        cnt_next = '0;
                        state_next = S_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            cnt_reg <= '0;
            n_reg <= '0;
            pos_reg <= '0;
            step_reg <= '0;
            center_reg <= 1'b0;
            scan_reg <= 1'b0;
            xform_reg <= 1'b0;
            swap_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            n_reg <= n_next;
            pos_reg <= pos_next;
            step_reg <= step_next;
            center_reg <= center_next;
            scan_reg <= scan_next;
            xform_reg <= xform_next;
            swap_reg <= swap_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sa_reg <= sa_next;
        sb_reg <= sb_next;
        vax_reg <= vax_next;
        vay_reg <= vay_next;
        vbx_reg <= vbx_next;
        vby_reg <= vby_next;
        cenx_reg <= cenx_next;
        ceny_reg <= ceny_next;
        refx_reg <= refx_next;
        refy_reg <= refy_next;
        oldx_reg <= oldx_next;
        oldy_reg <= oldy_next;
    end

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        point_ready |-> !out_valid)
        else $error("Loading and emitting overlap.");
    a_pass_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PASS) |-> (pos_reg < n_reg))
        else $error("Ring position ran past the set size.");
    a_set_size: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_LOAD) |-> (n_reg != '0 && n_reg <= CW'(MAX_POINTS)))
        else $error("Set size out of range.");
    a_back_to_load: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && out_last) |=> (point_ready && cnt_reg == '0))
        else $error("Block did not return to loading after the last item.");
    a_drain_start: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy)
        else $error("Pass started with the distance pipeline busy.");
endmodule
`default_nettype wire

// File: hw/rtl/jpfo_cell.sv
`default_nettype none
module jpfo_cell
(
    input  wire logic                                clk,
    input  wire logic                                load_en,
    input  wire logic                                shift_en,
    input  wire logic                                is_tail,
    input  wire logic signed [jpfo_pkg::VAL_W-1:0]   pt_x,
    input  wire logic signed [jpfo_pkg::VAL_W-1:0]   pt_y,
    input  wire logic signed [jpfo_pkg::VAL_W-1:0]   nb_x,
    input  wire logic signed [jpfo_pkg::VAL_W-1:0]   nb_y,
    input  wire logic signed [jpfo_pkg::VAL_W-1:0]   ret_x,
    input  wire logic signed [jpfo_pkg::VAL_W-1:0]   ret_y,
    output logic signed [jpfo_pkg::VAL_W-1:0]        x,
    output logic signed [jpfo_pkg::VAL_W-1:0]        y
);
    logic signed [jpfo_pkg::VAL_W-1:0] x_reg;
    logic signed [jpfo_pkg::VAL_W-1:0] y_reg;

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            x_reg <= pt_x;
            y_reg <= pt_y;
        end
        else if (shift_en)
        begin
            x_reg <= is_tail ? ret_x : nb_x;
            y_reg <= is_tail ? ret_y : nb_y;
        end
    end

    assign x = x_reg;
    assign y = y_reg;
endmodule
`default_nettype wire

// File: hw/rtl/jpfo_dist.sv
`default_nettype none
module jpfo_dist
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire jpfo_pkg::issue_t                   issue,
    input  wire logic signed [jpfo_pkg::VAL_W-1:0]  ref_x,
    input  wire logic signed [jpfo_pkg::VAL_W-1:0]  ref_y,
    input  wire logic                               clr,
    input  wire logic                               clr_center,
    output logic                                    busy,
    output jpfo_pkg::best_t                         best
);
    logic                                s1_v_reg;
    logic                                s1_center_reg;
    logic [jpfo_pkg::CNT_W-1:0]          s1_pos_reg;
    logic signed [jpfo_pkg::DIF_W-1:0]   s1_dx_reg;
    logic signed [jpfo_pkg::DIF_W-1:0]   s1_dy_reg;
    logic signed [jpfo_pkg::VAL_W-1:0]   s1_x_reg;
    logic signed [jpfo_pkg::VAL_W-1:0]   s1_y_reg;
    logic                                s2_v_reg;
    logic                                s2_center_reg;
    logic [jpfo_pkg::CNT_W-1:0]          s2_pos_reg;
    logic [jpfo_pkg::SQ_W-1:0]           s2_sum_reg;
    logic signed [jpfo_pkg::VAL_W-1:0]   s2_x_reg;
    logic signed [jpfo_pkg::VAL_W-1:0]   s2_y_reg;
    logic                                found_reg;
    logic [jpfo_pkg::SQ_W-1:0]           bd_reg;
    logic [jpfo_pkg::CNT_W-1:0]          bpos_reg;
    logic signed [jpfo_pkg::VAL_W-1:0]   bx_reg;
    logic signed [jpfo_pkg::VAL_W-1:0]   by_reg;
    logic                                s1_v_next;
    logic signed [2*jpfo_pkg::DIF_W-1:0] sqx;
    logic signed [2*jpfo_pkg::DIF_W-1:0] sqy;
    logic                                upd;

    assign s1_v_next = issue.valid && (issue.center || (issue.pos > issue.step));
    assign sqx = s1_dx_reg * s1_dx_reg;
    assign sqy = s1_dy_reg * s1_dy_reg;
    assign upd = s2_v_reg && (s2_center_reg ? (s2_sum_reg < bd_reg) : (s2_sum_reg > bd_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= s1_v_next;
            s2_v_reg <= s1_v_reg;
            if (clr)
            begin
                found_reg <= 1'b0;
            end
            else if (upd)
            begin
                found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_center_reg <= issue.center;
        s1_pos_reg    <= issue.pos;
        s1_dx_reg     <= jpfo_pkg::DIF_W'(issue.x) - jpfo_pkg::DIF_W'(ref_x);
        s1_dy_reg     <= jpfo_pkg::DIF_W'(issue.y) - jpfo_pkg::DIF_W'(ref_y);
        s1_x_reg      <= issue.x;
        s1_y_reg      <= issue.y;
        s2_center_reg <= s1_center_reg;
        s2_pos_reg    <= s1_pos_reg;
        s2_sum_reg    <= jpfo_pkg::SQ_W'(sqx[36:0]) + jpfo_pkg::SQ_W'(sqy[36:0]);
        s2_x_reg      <= s1_x_reg;
        s2_y_reg      <= s1_y_reg;
        if (clr)
        begin
            bd_reg <= clr_center ? jpfo_pkg::ONE_SQ : '0;
        end
        else if (upd)
        begin
            bd_reg   <= s2_sum_reg;
            bpos_reg <= s2_pos_reg;
            bx_reg   <= s2_x_reg;
            by_reg   <= s2_y_reg;
        end
    end

    assign busy = s1_v_reg || s2_v_reg;
    assign best.found = found_reg;
    assign best.pos = bpos_reg;
    assign best.x = bx_reg;
    assign best.y = by_reg;
endmodule
`default_nettype wire

// File: verif/jitter_point_farthest_ordering_test.sv
`timescale 1ns / 1ps

typedef struct {
    logic signed [17:0] x;
    logic signed [17:0] y;
    logic               last;
} ordered_point_t;

class ordering_scoreboard;
    localparam int CAP = jpfo_pkg::MAX_POINTS_DEF;
    int             set_x[CAP];
    int             set_y[CAP];
    int             loaded;
    int             errors;
    ordered_point_t ordered_q[$];

    function new();
        loaded = 0;
        errors = 0;
    endfunction

    function void swap_slots(int a, int b);
        int t;
        t = set_x[a];
        set_x[a] = set_x[b];
        set_x[b] = t;
        t = set_y[a];
        set_y[a] = set_y[b];
        set_y[b] = t;
    endfunction

    function void order_set(int n);
        longint best;
        longint r2;
        longint far_d2;
        longint d2;
        int     center;
        int     far_idx;
        int     cx;
        int     cy;
        ordered_point_t p;
        best = longint'(1) << 28;
        center = 0;
        for (int k = 0; k < n; k++)
        begin
            r2 = longint'(set_x[k]) * set_x[k] + longint'(set_y[k]) * set_y[k];
            if (r2 < best)
            begin
                best = r2;
                center = k;
            end
        end
        cx = set_x[center];
        cy = set_y[center];
        for (int k = 0; k < n; k++)
        begin
            set_x[k] = (set_x[k] - cx) * 2;
            set_y[k] = (set_y[k] - cy) * 2;
        end
        if (center != 0)
            swap_slots(0, center);
        for (int i = 0; i + 2 < n; i++)
        begin
            far_d2 = 0;
            far_idx = i;
            for (int j = i + 1; j < n; j++)
            begin
                d2 = longint'(set_x[i] - set_x[j]) * (set_x[i] - set_x[j]) +
                     longint'(set_y[i] - set_y[j]) * (set_y[i] - set_y[j]);
                if (d2 > far_d2)
                begin
                    far_d2 = d2;
                    far_idx = j;
                end
            end
            swap_slots(i + 1, far_idx);
        end
        for (int k = 0; k < n; k++)
        begin
            p.x = set_x[k][17:0];
            p.y = set_y[k][17:0];
            p.last = (k == n - 1);
            ordered_q.push_back(p);
        end
    endfunction

    function void note_point(logic signed [15:0] x, logic signed [15:0] y, logic last);
        if (loaded < CAP)
        begin
            set_x[loaded] = x;
            set_y[loaded] = y;
            loaded++;
        end
        if (last)
        begin
            order_set(loaded);
            loaded = 0;
        end
    endfunction

    function void check_result(logic signed [17:0] x, logic signed [17:0] y, logic last);
        ordered_point_t e;
        if (ordered_q.size() == 0)
        begin
            $display("%0t: unexpected item x=%0d y=%0d last=%0d", $time, x, y, last);
            errors++;
            return;
        end
        e = ordered_q.pop_front();
        if (x !== e.x)
        begin
            $display("%0t: out_x expected %0d actual %0d", $time, e.x, x);
            errors++;
        end
        if (y !== e.y)
        begin
            $display("%0t: out_y expected %0d actual %0d", $time, e.y, y);
            errors++;
        end
        if (last !== e.last)
        begin
            $display("%0t: out_last expected %0d actual %0d", $time, e.last, last);
            errors++;
        end
    endfunction
endclass

module jitter_point_farthest_ordering_test;
    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                point_valid = 1'b0;
    logic                point_ready;
    logic signed [15:0]  point_x = '0;
    logic signed [15:0]  point_y = '0;
    logic                last_point = 1'b0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic signed [17:0]  out_x;
    logic signed [17:0]  out_y;
    logic                out_last;

    ordering_scoreboard sb = new();
    bit                 steady = 1'b0;
    bit                 hold_request = 1'b0;
    int                 items_sent = 0;
    logic signed [15:0] prev_x = '0;
    logic signed [15:0] prev_y = '0;

    jitter_point_farthest_ordering dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .point_valid(point_valid),
        .point_ready(point_ready),
        .point_x(point_x),
        .point_y(point_y),
        .last_point(last_point),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_x(out_x),
        .out_y(out_y),
        .out_last(out_last)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                sb.check_result(out_x, out_y, out_last);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = 600;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= steady || ($urandom_range(99) >= 14);
        end
    end

    task automatic send_point(logic signed [15:0] x, logic signed [15:0] y, logic last);
        while (!steady && $urandom_range(99) < 14)
        begin
            point_valid <= 1'b0;
            @(posedge clk);
        end
        point_valid <= 1'b1;
        point_x <= x;
        point_y <= y;
        last_point <= last;
        do
            @(posedge clk);
        while (!point_ready);
        sb.note_point(x, y, last);
        prev_x = x;
        prev_y = y;
        items_sent++;
    endtask

    task automatic send_set(int n);
        logic signed [15:0] x;
        logic signed [15:0] y;
        for (int k = 0; k < n; k++)
        begin
            case ($urandom_range(3))
                0:
                begin
                    x = 16'($urandom);
                    y = 16'($urandom);
                end
                1:
                begin
                    x = 16'(int'($urandom_range(24000)) - 12000);
                    y = 16'(int'($urandom_range(24000)) - 12000);
                end
                2:
                begin
                    x = prev_x;
                    y = prev_y;
                end
                default:
                begin
                    x = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
                    y = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
                end
            endcase
            send_point(x, y, k == n - 1);
        end
    endtask

    task automatic drain();
        point_valid <= 1'b0;
        while (sb.ordered_q.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int n;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_point(16'sh7fff, 16'sh8000, 1'b1);
        send_point(16'sh8000, 16'sh7fff, 1'b0);
        send_point(16'sh0000, 16'sh0000, 1'b1);
        send_point(16'sh4000, 16'sh0000, 1'b0);
        send_point(16'sh0000, 16'sh4000, 1'b0);
        send_point(16'sh7fff, 16'sh7fff, 1'b1);
        send_point(16'sh0100, 16'sh0100, 1'b0);
        send_point(16'sh0100, 16'sh0100, 1'b0);
        send_point(16'sh0100, 16'sh0100, 1'b0);
        send_point(16'sh0100, 16'sh0100, 1'b1);
        send_point(16'sh8000, 16'sh8000, 1'b0);
        send_point(16'sh1000, 16'shf000, 1'b0);
        send_point(16'shf000, 16'sh1000, 1'b0);
        send_point(16'sh7fff, 16'sh0000, 1'b1);
        drain();
        send_set(35);
        drain();
        send_set(32);

        while (items_sent < 415)
        begin
            steady = (items_sent > 200 && items_sent < 280);
            if (items_sent > 120 && items_sent < 130)
                hold_request = 1'b1;
            if ($urandom_range(99) < 5)
                n = $urandom_range(36, 30);
            else
                n = $urandom_range(10, 1);
            send_set(n);
            if ($urandom_range(99) < 8)
                drain();
        end
        drain();
        repeat (100) @(posedge clk);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #8ms;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule

// File: sim.f
hw/rtl/jpfo_pkg.sv
hw/rtl/jpfo_cell.sv
hw/rtl/jpfo_dist.sv
hw/rtl/jitter_point_farthest_ordering.sv
verif/jitter_point_farthest_ordering_test.sv
